>>> hw/rtl/priority_ready_queue_unit_assert.svh
// Assertion macros for the priority ready queue unit.
`ifndef PRIORITY_READY_QUEUE_UNIT_ASSERT_SVH
`define PRIORITY_READY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define PRQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("priority ready queue assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define PRQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("priority ready queue assertion failed");

`endif

>>> hw/rtl/prq_pkg.sv
// Types and codes shared by the priority ready queue modules.
package prq_pkg;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic       opcode;
    logic [7:0] proc_id;
    logic [7:0] prio;
  } req_t;

  typedef struct packed {
    logic [7:0] out_id;
    logic [7:0] out_prio;
    logic [1:0] status;
    logic [4:0] occupancy;
  } res_t;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] prio;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch_req;
    logic       rd_head;
    logic       rd_below;
    logic       wr_new;
    logic       wr_shift;
    logic       k_load;
    logic       k_dec;
    logic       head_inc;
    logic       count_inc;
    logic       count_dec;
    logic       emit;
    logic       emit_head;
    logic [1:0] status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic k_zero;
    logic stop;
  } sts_t;

endpackage

>>> hw/rtl/prq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

>>> hw/rtl/prq_ctrl.sv
// Controller state machine for the priority ready queue.
module prq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          opcode_i,
  input  prq_pkg::sts_t sts_i,
  output prq_pkg::cmd_t cmd_o,
  output logic          busy
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StDeq   = 2'd1;
  localparam logic [1:0] StShift = 2'd2;

  logic [1:0] state_q, state_d;

  // Decode commands and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.latch_req = 1'b1;
          if (opcode_i == prq_pkg::OP_DEQ) begin
            if (sts_i.empty) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = prq_pkg::STATUS_EMPTY;
            end else begin
              cmd_o.rd_head = 1'b1;
              state_d       = StDeq;
            end
          end else begin
            if (sts_i.full) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = prq_pkg::STATUS_FULL;
            end else begin
              cmd_o.k_load   = 1'b1;
              cmd_o.rd_below = 1'b1;
              state_d        = StShift;
            end
          end
        end
      end
      StDeq: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_head = 1'b1;
        cmd_o.status    = prq_pkg::STATUS_OK;
        cmd_o.head_inc  = 1'b1;
        cmd_o.count_dec = 1'b1;
        state_d         = StIdle;
      end
      StShift: begin
        // Place the new entry at the bottom or above an equal or higher priority slot
        priority if (sts_i.k_zero || sts_i.stop) begin
          cmd_o.wr_new    = 1'b1;
          cmd_o.count_inc = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.status    = prq_pkg::STATUS_OK;
          state_d         = StIdle;
        end else begin
          cmd_o.wr_shift = 1'b1;
          cmd_o.k_dec    = 1'b1;
          cmd_o.rd_below = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign busy = (state_q != StIdle);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/prq_dp.sv
// Datapath for the priority ready queue: circular entry store, pointers, result.
module prq_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  prq_pkg::req_t req_i,
  input  prq_pkg::cmd_t cmd_i,
  output prq_pkg::sts_t sts_o,
  output prq_pkg::res_t res_o,
  output logic          res_valid_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DepthW    = (AW+1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] HeadLast  = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DepthCnt  = CW'(QUEUE_DEPTH);

  logic [AW-1:0]   head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   k_q, k_d;
  prq_pkg::req_t   req_q;
  prq_pkg::res_t   res_q, res_d;
  logic            res_valid_q;

  logic [AW-1:0]   rd_idx;
  logic [AW-1:0]   rd_addr;
  logic            rd_en;
  logic [AW-1:0]   wr_addr;
  logic            wr_en;
  prq_pkg::entry_t wr_entry;
  prq_pkg::entry_t rd_entry;
  logic [15:0]     rd_raw;
  logic [CW+4:0]   occ_wide;

  // Map a queue position to a physical slot behind the head
  function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] head,
                                            input logic [AW-1:0] idx);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, idx};
    if (sum >= DepthW) begin
      sum = sum - DepthW;
    end
    return sum[AW-1:0];
  endfunction

  // Load or step back the shift position
  always_comb begin
    k_d = k_q;
    if (cmd_i.k_load) begin
      k_d = count_q[AW-1:0];
    end else if (cmd_i.k_dec) begin
      k_d = k_q - AW'(1);
    end
  end

  // Read the head, or the slot just below the shift position
  assign rd_idx  = cmd_i.rd_head ? '0 : (k_d - AW'(1));
  assign rd_en   = cmd_i.rd_head || (cmd_i.rd_below && (k_d != '0));
  assign rd_addr = to_phys(head_q, rd_idx);

  // Write the new entry or move the entry below up by one
  assign rd_entry = prq_pkg::entry_t'(rd_raw);
  assign wr_en    = cmd_i.wr_new || cmd_i.wr_shift;
  assign wr_addr  = to_phys(head_q, k_q);
  always_comb begin
    if (cmd_i.wr_new) begin
      wr_entry.id   = req_q.proc_id;
      wr_entry.prio = req_q.prio;
    end else begin
      wr_entry = rd_entry;
    end
  end

  prq_ram #(
    .WIDTH ($bits(prq_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_entry),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_raw)
  );

  // Update head and count
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.head_inc) begin
      head_d = (head_q == HeadLast) ? '0 : (head_q + AW'(1));
    end
    if (cmd_i.count_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.count_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  // Build the result
  assign occ_wide = {5'b0, count_d};
  always_comb begin
    res_d.out_id    = cmd_i.emit_head ? rd_entry.id : '0;
    res_d.out_prio  = cmd_i.emit_head ? rd_entry.prio : '0;
    res_d.status    = cmd_i.status;
    res_d.occupancy = occ_wide[4:0];
  end

  assign sts_o.empty  = (count_q == '0);
  assign sts_o.full   = (count_q == DepthCnt);
  assign sts_o.k_zero = (k_q == '0);
  assign sts_o.stop   = (rd_entry.prio >= req_q.prio);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      k_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      k_q         <= k_d;
      res_valid_q <= cmd_i.emit;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_q <= req_i;
    end
    if (cmd_i.emit) begin
      res_q <= res_d;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

>>> hw/rtl/priority_ready_queue_unit.sv
// Top level of the priority ready queue unit.
// A request is taken at a clock edge where start is high and busy is low.
// Opcode enqueue inserts proc_id/prio behind every stored entry of equal or
// higher priority; opcode dequeue removes the head and returns it.
// Each request gives one result on res_o, marked by res_valid_o for exactly
// one cycle; the receiver cannot stall it and must take it in that cycle.
// Sequence from the accepting edge to the edge that takes the result:
//   dequeue on empty, enqueue on full: answered from idle, busy never rises.
//   dequeue: the head is read from the entry RAM (registered), then returned while busy.
//   enqueue: busy during the insertion walk over the stored entries of lower
//   priority; the walk moves one entry per cycle through the single-port-read,
//   single-port-write entry RAM.
// A new request may be taken in the cycle its predecessor's result is shown.
// Entries live in a circular RAM behind a head pointer; only slots below the
// count are read, so the RAM needs no clearing. Reset empties the queue at
// once and drops any request in progress.
`include "priority_ready_queue_unit_assert.svh"

module priority_ready_queue_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  prq_pkg::req_t req_i,
  output logic          res_valid_o,
  output prq_pkg::res_t res_o
);

  localparam logic [4:0] FullOcc = 5'(QUEUE_DEPTH);

  prq_pkg::cmd_t cmd;
  prq_pkg::sts_t sts;
  logic          accept;

  assign accept = start && !busy;

  prq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (req_i.opcode),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  prq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

  // An accepted request either keeps the unit busy or answers at once
  `PRQ_ASSERT_NEXT(a_accept_progress, accept, busy || res_valid_o)
  // A full report carries the full count and no entry
  `PRQ_ASSERT_NOW(a_full_result, res_valid_o && (res_o.status == prq_pkg::STATUS_FULL),
                  (res_o.occupancy == FullOcc) && (res_o.out_id == '0))
  // An empty report carries a zero count and no entry
  `PRQ_ASSERT_NOW(a_empty_result, res_valid_o && (res_o.status == prq_pkg::STATUS_EMPTY),
                  (res_o.occupancy == '0) && (res_o.out_prio == '0))
  // A busy controller never issues a request latch
  `PRQ_ASSERT_NOW(a_no_latch_busy, busy, !cmd.latch_req)

endmodule

>>> tb/sv/priority_ready_queue_unit_tb.sv
// Self-checking testbench for the priority ready queue unit.
`timescale 1ns / 100ps

module priority_ready_queue_unit_tb;
  import prq_pkg::*;

  localparam int          QUEUE_DEPTH  = 16;
  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 24;

  // Track queue contents and check every result against the predicted one.
  class ready_queue_scoreboard;
    entry_t      held[$];
    res_t        pending[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Apply one accepted request to the local queue and store its result.
    function void note_request(req_t r);
      res_t   exp;
      entry_t e;
      int     pos;
      exp = '0;
      if (r.opcode == OP_ENQ) begin
        if (held.size() >= QUEUE_DEPTH) begin
          exp.status = STATUS_FULL;
        end else begin
          // insert behind every entry of equal or higher priority
          pos = 0;
          while (pos < held.size() && held[pos].prio >= r.prio) pos++;
          e.id   = r.proc_id;
          e.prio = r.prio;
          held.insert(pos, e);
          exp.status = STATUS_OK;
        end
      end else begin
        if (held.size() == 0) begin
          exp.status = STATUS_EMPTY;
        end else begin
          e = held.pop_front();
          exp.out_id   = e.id;
          exp.out_prio = e.prio;
          exp.status   = STATUS_OK;
        end
      end
      exp.occupancy = 5'(held.size());
      pending.push_back(exp);
    endfunction

    // Compare one result with the oldest stored one.
    function void check_result(res_t got);
      res_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result with no request outstanding: id %0d prio %0d st %0d occ %0d",
                   $realtime, got.out_id, got.out_prio, got.status, got.occupancy);
        return;
      end
      exp = pending.pop_front();
      if (got.out_id !== exp.out_id || got.out_prio !== exp.out_prio ||
          got.status !== exp.status || got.occupancy !== exp.occupancy) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch id/prio/st/occ: exp %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                   $realtime, exp.out_id, exp.out_prio, exp.status, exp.occupancy,
                   got.out_id, got.out_prio, got.status, got.occupancy);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        res_valid_o;
  res_t        res_o;
  int unsigned cycle_count = 0;

  ready_queue_scoreboard sb = new();

  priority_ready_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always #4 clk_i = ~clk_i;

  // Watch both handshakes at each edge; check results before noting requests.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o === 1'b1) sb.check_result(res_o);
      if (start && busy === 1'b0) sb.note_request(req_i);
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("priority_ready_queue_unit_tb NOT OK");
      $finish;
    end
  end

  function automatic req_t make_req(logic op, logic [7:0] id, logic [7:0] pr);
    req_t r;
    r.opcode  = op;
    r.proc_id = id;
    r.prio    = pr;
    return r;
  endfunction

  // Mostly short gaps, a few long ones; none in quiet stretches.
  function automatic int unsigned next_gap(bit quiet);
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Hold one request until it is taken, then idle for the given gap.
  task automatic issue_request(req_t r, int unsigned gap);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst_len;
    int unsigned enq_pct;
    int unsigned prio_mode;
    logic [7:0]  base_prio;
    logic [7:0]  pr;
    logic        op;
    bit          quiet;

    start  = 1'b0;
    req_i  = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Dequeue on empty, field extremes, ties kept in arrival order.
    issue_request(make_req(OP_DEQ, 8'hff, 8'hff), next_gap(0));
    issue_request(make_req(OP_ENQ, 8'hff, 8'h00), next_gap(0));
    issue_request(make_req(OP_ENQ, 8'h00, 8'hff), next_gap(0));
    issue_request(make_req(OP_ENQ, 8'h01, 8'h80), next_gap(0));
    issue_request(make_req(OP_ENQ, 8'h02, 8'h80), next_gap(0));
    issue_request(make_req(OP_ENQ, 8'h03, 8'h80), next_gap(0));
    issue_request(make_req(OP_ENQ, 8'h04, 8'h81), next_gap(0));
    issue_request(make_req(OP_ENQ, 8'h05, 8'h00), next_gap(0));
    issue_request(make_req(OP_ENQ, 8'haa, 8'h7f), next_gap(0));
    repeat (9) issue_request(make_req(OP_DEQ, 8'h55, 8'haa), next_gap(0));

    // Random bursts that lean toward filling, draining or holding the level.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       enq_pct = 85;
        1:       enq_pct = 20;
        default: enq_pct = 55;
      endcase
      burst_len = $urandom_range(4, 40);
      prio_mode = $urandom_range(0, 9);
      base_prio = 8'($urandom_range(0, 255));
      quiet     = ($urandom_range(0, 3) == 0);
      repeat (burst_len) begin
        op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        if (prio_mode < 4)
          pr = base_prio + 8'($urandom_range(0, 3));
        else if (prio_mode == 4)
          pr = $urandom_range(0, 1) ? 8'hff : 8'h00;
        else
          pr = 8'($urandom_range(0, 255));
        issue_request(make_req(op, 8'($urandom_range(0, 255)), pr), next_gap(quiet));
        sent++;
      end
    end
    start <= 1'b0;

    // Drain outstanding results, then watch for strays.
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("priority_ready_queue_unit_tb OK");
    else
      $display("priority_ready_queue_unit_tb NOT OK");
    $finish;
  end

endmodule
